FILE: hdl/estm_pkg.sv
// Shared constants, codes and control types of the escape sequence trie matcher.
`default_nettype none
package estm_pkg;

    localparam int NODES_DEF  = 64;
    localparam int LEAVES_DEF = 128;

    // action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_MATCH  = 2'd1;
    localparam logic [1:0] ACT_FLUSH  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_PENDING   = 3'd0;
    localparam logic [2:0] ST_KEY       = 3'd1;
    localparam logic [2:0] ST_MOUSE     = 3'd2;
    localparam logic [2:0] ST_NOMATCH   = 3'd3;
    localparam logic [2:0] ST_INSERTED  = 3'd4;
    localparam logic [2:0] ST_DUPLICATE = 3'd5;
    localparam logic [2:0] ST_ERROR     = 3'd6;
    localparam logic [2:0] ST_IDLE      = 3'd7;

    localparam logic [4:0] LEN_MAX = 5'd31;

    typedef struct packed {
        logic       is_mouse;
        logic [1:0] kind;
        logic [9:0] code;
        logic [7:0] mods;
    } t_leaf;

    // controller -> datapath
    typedef struct packed {
        logic clear;     // write one empty slot of the clearing pass
        logic accept;    // take the input word, start the child read
        logic exec;      // resolve the word against the read slot
        logic leaf_out;  // present the leaf that was just read
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic leaf_hit;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: hdl/estm_ctrl.sv
// Sequencing state machine of the escape sequence trie matcher.
`default_nettype none
module estm_ctrl import estm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_LEAF  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the result register can take the word
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.leaf_hit ? S_LEAF : S_IDLE;
                end
            end
            S_LEAF: begin
                if (i_sts.out_free) begin
                    o_cmd.leaf_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/estm_datapath.sv
// Trie memories, walk registers and result register of the escape sequence trie matcher.
`default_nettype none
module estm_datapath import estm_pkg::*; #(
    parameter int NODES  = NODES_DEF,
    parameter int LEAVES = LEAVES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    output t_sts            o_sts,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_is_last,
    input  wire logic       i_is_mouse,
    input  wire logic [1:0] i_key_kind,
    input  wire logic [9:0] i_key_code,
    input  wire logic [7:0] i_key_mods,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [2:0]      o_status,
    output logic [4:0]      o_match_length,
    output logic [1:0]      o_found_kind,
    output logic [9:0]      o_found_code,
    output logic [7:0]      o_found_mods
);

    localparam int NODE_W   = $clog2(NODES);
    localparam int LEAF_W   = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int NCNT_W   = $clog2(NODES + 1);
    localparam int LCNT_W   = $clog2(LEAVES + 1);
    localparam int SLOT_PAY = (NODE_W > LEAF_W) ? NODE_W : LEAF_W;
    localparam int SLOT_W   = SLOT_PAY + 1;
    localparam int ADDR_W   = NODE_W + 8;
    localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(NODES * 256 - 1);
    localparam logic [NCNT_W-1:0] NODES_LIM = NCNT_W'(NODES);
    localparam logic [LCNT_W-1:0] LEAF_LIM  = LCNT_W'(LEAVES);

    // slot: top bit marks a leaf, zero means empty, else a child node index
    logic [SLOT_W-1:0] r_child_mem [NODES * 256];
    t_leaf             r_leaf_mem  [LEAVES];

    logic [SLOT_W-1:0] r_slot;
    t_leaf             r_leaf_rd;

    // walk state
    logic [NCNT_W-1:0] r_nodes_used, n_nodes_used;
    logic [LCNT_W-1:0] r_leaves_used, n_leaves_used;
    logic [NODE_W-1:0] r_match_node, n_match_node;
    logic [4:0]        r_match_count, n_match_count;
    logic [NODE_W-1:0] r_insert_node, n_insert_node;
    logic              r_insert_failed, n_insert_failed;
    logic [ADDR_W-1:0] r_clr_addr;

    // word under work
    logic [1:0]        r_act;
    logic              r_last;
    t_leaf             r_item;
    logic [ADDR_W-1:0] r_addr;
    logic [4:0]        r_hit_len;

    // result register
    logic       r_out_valid;
    logic [2:0] r_status;
    logic [4:0] r_len;
    logic [1:0] r_kind;
    logic [9:0] r_code;
    logic [7:0] r_mods;

    logic              slot_empty, slot_leaf, leaf_hit;
    logic [NODE_W-1:0] slot_node;
    logic [4:0]        len_next;
    logic              nodes_avail, leaves_avail;
    logic              child_we, leaf_we, out_load;
    logic [2:0]        exec_status;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [SLOT_W-1:0] wr_slot;

    assign slot_empty   = (r_slot == '0);
    assign slot_leaf    = r_slot[SLOT_W-1];
    assign slot_node    = r_slot[NODE_W-1:0];
    assign leaf_hit     = (r_act == ACT_MATCH) && slot_leaf;
    assign len_next     = (r_match_count != LEN_MAX) ? r_match_count + 5'd1 : LEN_MAX;
    assign nodes_avail  = (r_nodes_used < NODES_LIM);
    assign leaves_avail = (r_leaves_used < LEAF_LIM);

    assign o_sts.clear_done = (r_clr_addr == CLR_LAST);
    assign o_sts.leaf_hit   = leaf_hit;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign rd_addr = {((i_action == ACT_INSERT) ? r_insert_node : r_match_node), i_data_byte};
    assign wr_addr = i_cmd.clear ? r_clr_addr : r_addr;
    always_comb begin
        if (i_cmd.clear) begin
            wr_slot = '0;
        end else if (r_last) begin
            wr_slot = {1'b1, SLOT_PAY'(r_leaves_used[LEAF_W-1:0])};
        end else begin
            wr_slot = {1'b0, SLOT_PAY'(r_nodes_used[NODE_W-1:0])};
        end
    end

    // resolve the word against the slot that was read
    always_comb begin
        n_nodes_used    = r_nodes_used;
        n_leaves_used   = r_leaves_used;
        n_match_node    = r_match_node;
        n_match_count   = r_match_count;
        n_insert_node   = r_insert_node;
        n_insert_failed = r_insert_failed;
        child_we        = 1'b0;
        leaf_we         = 1'b0;
        exec_status     = ST_IDLE;
        case (r_act)
            ACT_INSERT: begin
                if (r_insert_failed) begin
                    exec_status = ST_ERROR;
                end else if (r_last) begin
                    if (!slot_empty) begin
                        exec_status = ST_DUPLICATE;
                    end else if (leaves_avail) begin
                        child_we      = 1'b1;
                        leaf_we       = 1'b1;
                        n_leaves_used = r_leaves_used + LCNT_W'(1);
                        exec_status   = ST_INSERTED;
                    end else begin
                        exec_status = ST_ERROR;
                    end
                end else if (slot_leaf) begin
                    exec_status     = ST_ERROR;
                    n_insert_failed = 1'b1;
                end else if (!slot_empty) begin
                    n_insert_node = slot_node;
                end else if (nodes_avail) begin
                    child_we      = 1'b1;
                    n_insert_node = r_nodes_used[NODE_W-1:0];
                    n_nodes_used  = r_nodes_used + NCNT_W'(1);
                end else begin
                    exec_status     = ST_ERROR;
                    n_insert_failed = 1'b1;
                end
                if (r_last) begin
                    n_insert_node   = '0;
                    n_insert_failed = 1'b0;
                end
            end
            ACT_MATCH: begin
                if (slot_leaf) begin
                    n_match_node  = '0;
                    n_match_count = '0;
                end else if (!slot_empty) begin
                    n_match_node  = slot_node;
                    n_match_count = len_next;
                    exec_status   = ST_PENDING;
                end else begin
                    n_match_node  = '0;
                    n_match_count = '0;
                    exec_status   = ST_NOMATCH;
                end
            end
            ACT_FLUSH: begin
                if (r_match_node != '0) begin
                    n_match_node  = '0;
                    n_match_count = '0;
                    exec_status   = ST_NOMATCH;
                end
            end
            default: begin
                exec_status = ST_IDLE;
            end
        endcase
    end

    assign out_load = (i_cmd.exec && !leaf_hit) || i_cmd.leaf_out;

    // child memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear || (i_cmd.exec && child_we)) begin
            r_child_mem[wr_addr] <= wr_slot;
        end
        if (i_cmd.accept) begin
            r_slot <= r_child_mem[rd_addr];
        end
    end

    // leaf memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && leaf_we) begin
            r_leaf_mem[r_leaves_used[LEAF_W-1:0]] <= r_item;
        end
        if (i_cmd.exec && leaf_hit) begin
            r_leaf_rd <= r_leaf_mem[r_slot[LEAF_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes_used    <= NCNT_W'(1);
            r_leaves_used   <= '0;
            r_match_node    <= '0;
            r_match_count   <= '0;
            r_insert_node   <= '0;
            r_insert_failed <= 1'b0;
            r_clr_addr      <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.exec) begin
                r_nodes_used    <= n_nodes_used;
                r_leaves_used   <= n_leaves_used;
                r_match_node    <= n_match_node;
                r_match_count   <= n_match_count;
                r_insert_node   <= n_insert_node;
                r_insert_failed <= n_insert_failed;
            end
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act           <= i_action;
            r_last          <= i_is_last;
            r_item.is_mouse <= i_is_mouse;
            r_item.kind     <= i_key_kind;
            r_item.code     <= i_key_code;
            r_item.mods     <= i_key_mods;
            r_addr          <= rd_addr;
        end
        if (i_cmd.exec) begin
            r_hit_len <= len_next;
        end
        if (i_cmd.leaf_out) begin
            r_status <= r_leaf_rd.is_mouse ? ST_MOUSE : ST_KEY;
            r_len    <= r_hit_len;
            r_kind   <= r_leaf_rd.is_mouse ? 2'd0 : r_leaf_rd.kind;
            r_code   <= r_leaf_rd.is_mouse ? 10'd0 : r_leaf_rd.code;
            r_mods   <= r_leaf_rd.is_mouse ? 8'd0 : r_leaf_rd.mods;
        end else if (i_cmd.exec && !leaf_hit) begin
            r_status <= exec_status;
            r_len    <= '0;
            r_kind   <= '0;
            r_code   <= '0;
            r_mods   <= '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_match_length = r_len;
    assign o_found_kind   = r_kind;
    assign o_found_code   = r_code;
    assign o_found_mods   = r_mods;

endmodule
`default_nettype wire

FILE: hdl/escape_sequence_trie_matcher.sv
// Top level of the escape sequence trie matcher: controller, datapath and checks.
`default_nettype none
// Byte trie matcher for key escape sequences. Insert words build sequences
// into a trie of NODES nodes, each with 256 child slots, held in one
// synchronous memory of NODES*256 entries; the final byte of a sequence hangs
// a key leaf or a mouse prefix leaf off its slot in a LEAVES-entry leaf
// memory. Match words walk the trie from the current match node and answer
// pending, key (with length and leaf contents), mouse prefix (with length) or
// no match; flush turns a partial match into no match. Every input word gives
// exactly one result word. After reset the block runs a clearing pass that
// empties the child memory one entry a cycle, with o_in_ready low throughout.
// Afterwards the child memory read of a word is issued as the word is taken,
// and a resolve step then writes back a new node or leaf. A match that lands
// on a leaf adds a step for the leaf memory read. A finished result sits in an
// output register; the next word is taken meanwhile, and its resolve step
// holds only while that register is still full.
module escape_sequence_trie_matcher import estm_pkg::*; #(
    parameter int NODES  = NODES_DEF,
    parameter int LEAVES = LEAVES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_action,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_is_last,
    input  wire logic       i_is_mouse,
    input  wire logic [1:0] i_key_kind,
    input  wire logic [9:0] i_key_code,
    input  wire logic [7:0] i_key_mods,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [2:0]      o_status,
    output logic [4:0]      o_match_length,
    output logic [1:0]      o_found_kind,
    output logic [9:0]      o_found_code,
    output logic [7:0]      o_found_mods
);

    t_cmd cmd;
    t_sts sts;

    // sequencing: clear pass, take word, resolve, optional leaf read
    estm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // memories, walk registers and the result register
    estm_datapath #(
        .NODES  (NODES),
        .LEAVES (LEAVES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_data_byte    (i_data_byte),
        .i_is_last      (i_is_last),
        .i_is_mouse     (i_is_mouse),
        .i_key_kind     (i_key_kind),
        .i_key_code     (i_key_code),
        .i_key_mods     (i_key_mods),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_match_length (o_match_length),
        .o_found_kind   (o_found_kind),
        .o_found_code   (o_found_code),
        .o_found_mods   (o_found_mods)
    );

    // one word at a time: right after a word is taken, input is closed
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a word is still in flight");

    // the clearing pass keeps input closed right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("input open before the child memory was cleared");

    // leaf fields only accompany a key result
    a_fields_only_on_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_KEY) |->
            (o_found_kind == 2'd0) && (o_found_code == 10'd0) && (o_found_mods == 8'd0))
        else $error("leaf fields set on a non-key result");

    // a leaf hit always covers at least its own byte
    a_hit_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_status == ST_KEY) || (o_status == ST_MOUSE)) |->
            (o_match_length != 5'd0))
        else $error("leaf hit reported with zero length");

endmodule
`default_nettype wire
